// File: rtl/core/mfld_pkg.sv
// ----------------------------------------------------------------------------
// mfld_pkg
// Shared types and constants for the monochrome frame store line drawer:
// command and result beats, opcodes and default geometry.
// ----------------------------------------------------------------------------
package mfld_pkg;

    localparam int DEF_WIDTH       = 200;
    localparam int DEF_HEIGHT      = 200;
    localparam int DEF_STORE_BYTES = 5000;

    // pixel and byte index width: covers 511 rows of 64 bytes plus a column byte
    localparam int IDX_W = 16;

    localparam logic [7:0] LEFT_BIT   = 8'h80;
    localparam logic [7:0] FILL_RESET = 8'hFF;

    localparam logic [2:0] OP_SET_PIXEL = 3'd0;
    localparam logic [2:0] OP_DRAW_LINE = 3'd1;
    localparam logic [2:0] OP_FILL_RECT = 3'd2;
    localparam logic [2:0] OP_FILL_BUF  = 3'd3;
    localparam logic [2:0] OP_READ_BYTE = 3'd4;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [8:0]  start_x;
        logic [8:0]  start_y;
        logic [8:0]  end_x;
        logic [8:0]  end_y;
        logic [8:0]  rect_width;
        logic [8:0]  rect_height;
        logic [7:0]  paint_value;
        logic [12:0] byte_address;
    } t_cmd;

    typedef struct packed {
        logic [7:0] read_data;
        logic       command_done;
    } t_result;

endpackage

// File: rtl/core/mfld_frame_ram.sv
// ----------------------------------------------------------------------------
// mfld_frame_ram
// Single-port byte store for the frame buffer: one write or one read per
// cycle at a shared address, read data registered.
// ----------------------------------------------------------------------------
module mfld_frame_ram #(
    parameter int DEPTH = 5000,
    parameter int AW    = 13
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_addr,
    input  logic [7:0]    i_wr_data,
    output logic [7:0]    o_rd_data
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/core/mono_framebuffer_line_drawer.sv
// ----------------------------------------------------------------------------
// mono_framebuffer_line_drawer
// 1 bpp frame store with set pixel, Bresenham line, rectangle fill, buffer
// fill and byte read, run one command at a time by a small sequencer around
// a single-port byte memory.
// ----------------------------------------------------------------------------
// set pixel: start, address, read, write and step states, then the result strobe;
//   each line or rectangle pixel runs address, read, write and step, no write if skipped
// fill writes each byte in turn; read byte answers from S_RD_DATA, bad opcode from S_START
// throughput is one command at a time, bounded by the single memory port
// reset: a clearing pass writes 0xFF to every byte, busy high
// results come as one-cycle strobes; the receiver cannot stall them
module mono_framebuffer_line_drawer #(
    parameter int WIDTH       = mfld_pkg::DEF_WIDTH,
    parameter int HEIGHT      = mfld_pkg::DEF_HEIGHT,
    parameter int STORE_BYTES = mfld_pkg::DEF_STORE_BYTES
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  mfld_pkg::t_cmd   i_cmd,
    output logic             o_strobe,
    output mfld_pkg::t_result o_result
);

    import mfld_pkg::*;

    localparam int ROW_BYTES = (WIDTH + 7) / 8;
    localparam int AW        = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;

    typedef enum logic [7:0] {
        S_IDLE    = 8'b0000_0001,
        S_FILL    = 8'b0000_0010,
        S_START   = 8'b0000_0100,
        S_P_ADDR  = 8'b0000_1000,
        S_P_READ  = 8'b0001_0000,
        S_P_WRITE = 8'b0010_0000,
        S_NEXT    = 8'b0100_0000,
        S_RD_DATA = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;
    logic   r_strobe, n_strobe;
    logic   r_emit, n_emit;
    logic [AW-1:0] r_fill_addr, n_fill_addr;
    logic [7:0]    r_fill_val, n_fill_val;

    t_cmd    r_cmd, n_cmd;
    t_result r_result, n_result;
    logic [9:0]  r_px, n_px;
    logic [9:0]  r_py, n_py;
    logic [8:0]  r_dx, n_dx;
    logic [8:0]  r_dy, n_dy;
    logic        r_xneg, n_xneg;
    logic        r_yneg, n_yneg;
    logic signed [11:0] r_err, n_err;
    logic [8:0]  r_ci, n_ci;
    logic [8:0]  r_cj, n_cj;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic        r_ok, n_ok;
    logic [7:0]  r_mask, n_mask;

    logic          ram_we;
    logic          ram_re;
    logic [AW-1:0] ram_addr;
    logic [7:0]    ram_wdata;
    logic [7:0]    ram_rdata;

    logic [8:0]  init_dx, init_dy;
    logic signed [12:0] line_e2, dx_s, dy_s;
    logic signed [11:0] dx_e, dy_e;
    logic        step_x, step_y, line_end;
    logic [IDX_W-1:0] pix_idx;
    logic        pix_ok, idx_in_store, rd_in_store, paint_white;

    mfld_frame_ram #(
        .DEPTH (STORE_BYTES),
        .AW    (AW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_we),
        .i_rd_en   (ram_re),
        .i_addr    (ram_addr),
        .i_wr_data (ram_wdata),
        .o_rd_data (ram_rdata)
    );

    assign init_dx = (r_cmd.end_x > r_cmd.start_x) ? (r_cmd.end_x - r_cmd.start_x)
                                                   : (r_cmd.start_x - r_cmd.end_x);
    assign init_dy = (r_cmd.end_y > r_cmd.start_y) ? (r_cmd.end_y - r_cmd.start_y)
                                                   : (r_cmd.start_y - r_cmd.end_y);

    assign dx_s    = $signed({4'b0, r_dx});
    assign dy_s    = $signed({4'b0, r_dy});
    assign dx_e    = $signed({3'b0, r_dx});
    assign dy_e    = $signed({3'b0, r_dy});
    assign line_e2 = $signed({r_err, 1'b0});
    assign step_x  = line_e2 > -dy_s;
    assign step_y  = line_e2 < dx_s;
    assign line_end = (r_px == {1'b0, r_cmd.end_x}) && (r_py == {1'b0, r_cmd.end_y});

    // byte index of the current pixel: row times row bytes plus column byte
    assign pix_idx = IDX_W'(r_py) * IDX_W'(ROW_BYTES) + IDX_W'(r_px[9:3]);
    assign pix_ok  = (32'(r_px) < WIDTH) && (32'(r_py) < HEIGHT);
    assign idx_in_store = 32'(r_idx) < STORE_BYTES;
    assign rd_in_store  = 32'(r_cmd.byte_address) < STORE_BYTES;
    assign paint_white  = r_cmd.paint_value != 8'd0;

    always_comb begin
        n_state     = r_state;
        n_strobe    = 1'b0;
        n_emit      = r_emit;
        n_fill_addr = r_fill_addr;
        n_fill_val  = r_fill_val;
        n_cmd       = r_cmd;
        n_result    = r_result;
        n_px        = r_px;
        n_py        = r_py;
        n_dx        = r_dx;
        n_dy        = r_dy;
        n_xneg      = r_xneg;
        n_yneg      = r_yneg;
        n_err       = r_err;
        n_ci        = r_ci;
        n_cj        = r_cj;
        n_idx       = r_idx;
        n_ok        = r_ok;
        n_mask      = r_mask;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        ram_addr    = r_fill_addr;
        ram_wdata   = r_fill_val;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_cmd   = i_cmd;
                    n_px    = {1'b0, i_cmd.start_x};
                    n_py    = {1'b0, i_cmd.start_y};
                    n_ci    = 9'd0;
                    n_cj    = 9'd0;
                    n_state = S_START;
                end
            end
            S_FILL: begin
                ram_we      = 1'b1;
                ram_addr    = r_fill_addr;
                ram_wdata   = r_fill_val;
                n_fill_addr = r_fill_addr + AW'(1);
                if (r_fill_addr == AW'(STORE_BYTES - 1)) begin
                    n_fill_addr = '0;
                    n_state     = S_IDLE;
                    if (r_emit) begin
                        n_strobe = 1'b1;
                        n_result = '{read_data: 8'd0, command_done: 1'b1};
                    end
                end
            end
            S_START: begin
                case (r_cmd.opcode)
                    OP_SET_PIXEL: begin
                        n_state = S_P_ADDR;
                    end
                    OP_DRAW_LINE: begin
                        n_dx    = init_dx;
                        n_dy    = init_dy;
                        n_xneg  = !(r_cmd.start_x < r_cmd.end_x);
                        n_yneg  = !(r_cmd.start_y < r_cmd.end_y);
                        n_err   = $signed({3'b0, init_dx}) - $signed({3'b0, init_dy});
                        n_state = S_P_ADDR;
                    end
                    OP_FILL_RECT: begin
                        if (r_cmd.rect_width == 9'd0 || r_cmd.rect_height == 9'd0) begin
                            n_strobe = 1'b1;
                            n_result = '{read_data: 8'd0, command_done: 1'b1};
                            n_state  = S_IDLE;
                        end else begin
                            n_state = S_P_ADDR;
                        end
                    end
                    OP_FILL_BUF: begin
                        n_fill_addr = '0;
                        n_fill_val  = r_cmd.paint_value;
                        n_emit      = 1'b1;
                        n_state     = S_FILL;
                    end
                    OP_READ_BYTE: begin
                        ram_re   = rd_in_store;
                        ram_addr = AW'(r_cmd.byte_address);
                        n_state  = S_RD_DATA;
                    end
                    default: begin
                        n_strobe = 1'b1;
                        n_result = '{read_data: 8'd0, command_done: 1'b0};
                        n_state  = S_IDLE;
                    end
                endcase
            end
            S_P_ADDR: begin
                n_idx   = pix_idx;
                n_ok    = pix_ok;
                n_mask  = LEFT_BIT >> r_px[2:0];
                n_state = S_P_READ;
            end
            S_P_READ: begin
                if (r_ok && idx_in_store) begin
                    ram_re   = 1'b1;
                    ram_addr = r_idx[AW-1:0];
                    n_state  = S_P_WRITE;
                end else begin
                    // off the display or beyond the store: skip the pixel
                    n_state = S_NEXT;
                end
            end
            S_P_WRITE: begin
                ram_we    = 1'b1;
                ram_addr  = r_idx[AW-1:0];
                ram_wdata = paint_white ? (ram_rdata | r_mask) : (ram_rdata & ~r_mask);
                n_state   = S_NEXT;
            end
            S_NEXT: begin
                case (r_cmd.opcode)
                    OP_DRAW_LINE: begin
                        if (line_end) begin
                            n_strobe = 1'b1;
                            n_result = '{read_data: 8'd0, command_done: 1'b1};
                            n_state  = S_IDLE;
                        end else begin
                            n_err = r_err - (step_x ? dy_e : 12'sd0)
                                          + (step_y ? dx_e : 12'sd0);
                            if (step_x) begin
                                n_px = r_xneg ? (r_px - 10'd1) : (r_px + 10'd1);
                            end
                            if (step_y) begin
                                n_py = r_yneg ? (r_py - 10'd1) : (r_py + 10'd1);
                            end
                            n_state = S_P_ADDR;
                        end
                    end
                    OP_FILL_RECT: begin
                        if ({1'b0, r_ci} + 10'd1 < {1'b0, r_cmd.rect_width}) begin
                            n_ci    = r_ci + 9'd1;
                            n_px    = r_px + 10'd1;
                            n_state = S_P_ADDR;
                        end else if ({1'b0, r_cj} + 10'd1 < {1'b0, r_cmd.rect_height}) begin
                            n_ci    = 9'd0;
                            n_cj    = r_cj + 9'd1;
                            n_px    = {1'b0, r_cmd.start_x};
                            n_py    = r_py + 10'd1;
                            n_state = S_P_ADDR;
                        end else begin
                            n_strobe = 1'b1;
                            n_result = '{read_data: 8'd0, command_done: 1'b1};
                            n_state  = S_IDLE;
                        end
                    end
                    default: begin
                        n_strobe = 1'b1;
                        n_result = '{read_data: 8'd0, command_done: 1'b1};
                        n_state  = S_IDLE;
                    end
                endcase
            end
            S_RD_DATA: begin
                n_strobe = 1'b1;
                n_result = '{read_data: (rd_in_store ? ram_rdata : 8'd0), command_done: 1'b1};
                n_state  = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            // clearing pass paints the whole store white
            r_state     <= S_FILL;
            r_strobe    <= 1'b0;
            r_emit      <= 1'b0;
            r_fill_addr <= '0;
            r_fill_val  <= FILL_RESET;
        end else begin
            r_state     <= n_state;
            r_strobe    <= n_strobe;
            r_emit      <= n_emit;
            r_fill_addr <= n_fill_addr;
            r_fill_val  <= n_fill_val;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_result <= n_result;
        r_px     <= n_px;
        r_py     <= n_py;
        r_dx     <= n_dx;
        r_dy     <= n_dy;
        r_xneg   <= n_xneg;
        r_yneg   <= n_yneg;
        r_err    <= n_err;
        r_ci     <= n_ci;
        r_cj     <= n_cj;
        r_idx    <= n_idx;
        r_ok     <= n_ok;
        r_mask   <= n_mask;
    end

    assign busy     = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_result;

    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy)
        else $error("result beat while the sequencer is still busy");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted command did not raise busy");

    a_write_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_P_WRITE) |-> ($past(r_state) == S_P_READ))
        else $error("pixel write without its read");

    a_unknown_quick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_result.command_done) |-> $past(start && !busy, 2))
        else $error("not-done beat not two cycles after its command");

endmodule

// File: dv/mono_framebuffer_line_drawer_tb.sv
// ----------------------------------------------------------------------------
// mono_framebuffer_line_drawer_tb
// Self-checking bench for the 1 bpp frame store: a directed pass over pixel,
// line, rectangle, buffer fill, byte read and unused opcodes, then random
// command streams driven in bursts. A scoreboard keeps its own copy of the
// frame store, predicts each result beat and checks the strobed results.
// ----------------------------------------------------------------------------
module mono_framebuffer_line_drawer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mfld_pkg::*;

    localparam int WIDTH       = DEF_WIDTH;
    localparam int HEIGHT      = DEF_HEIGHT;
    localparam int STORE_BYTES = DEF_STORE_BYTES;
    localparam int ROW_BYTES   = (WIDTH + 7) / 8;
    localparam int COORD_MAX   = 511;
    localparam int ADDR_MAX    = 8191;

    localparam logic [2:0] OP_FIRST_UNUSED = 3'd5;
    localparam logic [2:0] OP_LAST_UNUSED  = 3'd7;

    localparam int RANDOM_ITEMS = 1000;
    localparam int DRAIN_LIMIT  = 50000;
    localparam int TAIL_CYCLES  = 16;
    localparam int TIMEOUT_NS   = 400_000_000;

    // ------------------------------------------------------------------------
    // scoreboard: shadow frame store and queue of pending result beats
    // ------------------------------------------------------------------------
    class frame_scoreboard;
        logic [7:0]  frame_bytes [STORE_BYTES];
        t_result     pending_q[$];
        int unsigned mismatches;
        int unsigned checked;
        int unsigned op_count [8];

        function new();
            foreach (frame_bytes[k]) frame_bytes[k] = FILL_RESET;
            mismatches = 0;
            checked    = 0;
            foreach (op_count[k]) op_count[k] = 0;
        endfunction

        function void paint_pixel(int x, int y, bit white);
            int         idx;
            logic [7:0] mask;
            if (x < 0 || y < 0 || x >= WIDTH || y >= HEIGHT) return;
            idx = y * ROW_BYTES + x / 8;
            if (idx >= STORE_BYTES) return;
            mask = LEFT_BIT >> (x % 8);
            if (white) frame_bytes[idx] = frame_bytes[idx] | mask;
            else       frame_bytes[idx] = frame_bytes[idx] & ~mask;
        endfunction

        // integer error stepping, both ends painted, off-display pixels dropped
        function void trace_line(int x0, int y0, int x1, int y1, bit white);
            int dx, dy, sx, sy, err, e2;
            dx  = (x1 > x0) ? x1 - x0 : x0 - x1;
            dy  = (y1 > y0) ? y1 - y0 : y0 - y1;
            sx  = (x0 < x1) ? 1 : -1;
            sy  = (y0 < y1) ? 1 : -1;
            err = dx - dy;
            forever begin
                paint_pixel(x0, y0, white);
                if (x0 == x1 && y0 == y1) break;
                e2 = 2 * err;
                if (e2 > -dy) begin
                    err -= dy;
                    x0  += sx;
                end
                if (e2 < dx) begin
                    err += dx;
                    y0  += sy;
                end
            end
        endfunction

        function void note_command(t_cmd c);
            t_result r;
            bit      white;
            white          = (c.paint_value != 8'd0);
            r.read_data    = 8'd0;
            r.command_done = 1'b1;
            op_count[c.opcode]++;
            case (c.opcode)
                OP_SET_PIXEL: begin
                    paint_pixel(int'(c.start_x), int'(c.start_y), white);
                end
                OP_DRAW_LINE: begin
                    trace_line(int'(c.start_x), int'(c.start_y),
                               int'(c.end_x), int'(c.end_y), white);
                end
                OP_FILL_RECT: begin
                    for (int j = 0; j < int'(c.rect_height); j++)
                        for (int i = 0; i < int'(c.rect_width); i++)
                            paint_pixel(int'(c.start_x) + i, int'(c.start_y) + j, white);
                end
                OP_FILL_BUF: begin
                    foreach (frame_bytes[k]) frame_bytes[k] = c.paint_value;
                end
                OP_READ_BYTE: begin
                    if (int'(c.byte_address) < STORE_BYTES)
                        r.read_data = frame_bytes[c.byte_address];
                end
                default: begin
                    r.command_done = 1'b0;
                end
            endcase
            pending_q.push_back(r);
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (pending_q.size() == 0) begin
                $display("%0t: result beat with nothing pending: read_data %h done %b",
                         $time, got.read_data, got.command_done);
                mismatches++;
                return;
            end
            want = pending_q.pop_front();
            checked++;
            if (got.read_data !== want.read_data) begin
                $display("%0t: read_data mismatch: expected %h actual %h",
                         $time, want.read_data, got.read_data);
                mismatches++;
            end
            if (got.command_done !== want.command_done) begin
                $display("%0t: command_done mismatch: expected %b actual %b",
                         $time, want.command_done, got.command_done);
                mismatches++;
            end
        endfunction

        function int pending();
            return pending_q.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // dut and clock
    // ------------------------------------------------------------------------
    logic    i_clk = 1'b0;
    logic    i_rst_n;
    logic    start;
    logic    busy;
    t_cmd    cmd_in;
    logic    o_strobe;
    t_result o_result;

    frame_scoreboard board;

    int burst_left;
    int last_x;
    int last_y;

    always #6 i_clk = ~i_clk;

    mono_framebuffer_line_drawer #(
        .WIDTH       (WIDTH),
        .HEIGHT      (HEIGHT),
        .STORE_BYTES (STORE_BYTES)
    ) uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_cmd    (cmd_in),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) board.check_result(o_result);
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    function automatic t_cmd make_cmd(logic [2:0] op, int sx, int sy, int ex, int ey,
                                      int w, int h, int pv, int addr);
        t_cmd c;
        c.opcode       = op;
        c.start_x      = 9'(sx);
        c.start_y      = 9'(sy);
        c.end_x        = 9'(ex);
        c.end_y        = 9'(ey);
        c.rect_width   = 9'(w);
        c.rect_height  = 9'(h);
        c.paint_value  = 8'(pv);
        c.byte_address = 13'(addr);
        return c;
    endfunction

    function automatic int clamp(int v, int hi);
        if (v < 0) return 0;
        if (v > hi) return hi;
        return v;
    endfunction

    // often near the recent activity so reads land on painted bytes
    function automatic int pick_coord(int near);
        int unsigned p;
        p = $urandom_range(0, 99);
        if (p < 45) return clamp(near + int'($urandom_range(0, 24)) - 12, COORD_MAX);
        if (p < 75) return int'($urandom_range(0, WIDTH - 1));
        return int'($urandom_range(0, COORD_MAX));
    endfunction

    function automatic int pick_paint();
        if ($urandom_range(0, 1) == 0) return 0;
        return int'($urandom_range(1, 255));
    endfunction

    function automatic t_cmd random_command();
        t_cmd        c;
        int unsigned p;
        int          rx, ry;
        // fields the opcode does not use still carry random bits
        c = make_cmd(3'($urandom_range(0, 7)), $urandom_range(0, COORD_MAX),
                     $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                     $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                     $urandom_range(0, COORD_MAX), $urandom_range(0, 255),
                     $urandom_range(0, ADDR_MAX));
        p = $urandom_range(0, 99);
        if (p < 58) begin
            c.start_x     = 9'(pick_coord(last_x));
            c.start_y     = 9'(pick_coord(last_y));
            c.paint_value = 8'(pick_paint());
            last_x        = clamp(int'(c.start_x), WIDTH - 1);
            last_y        = clamp(int'(c.start_y), HEIGHT - 1);
        end
        if (p < 20) begin
            c.opcode = OP_SET_PIXEL;
        end else if (p < 40) begin
            c.opcode = OP_DRAW_LINE;
            if ($urandom_range(0, 99) < 65) begin
                c.end_x = 9'(clamp(int'(c.start_x) + int'($urandom_range(0, 60)) - 30,
                                   COORD_MAX));
                c.end_y = 9'(clamp(int'(c.start_y) + int'($urandom_range(0, 60)) - 30,
                                   COORD_MAX));
            end
        end else if (p < 58) begin
            c.opcode = OP_FILL_RECT;
            case ($urandom_range(0, 9))
                0: begin
                    c.rect_width  = 9'($urandom_range(0, COORD_MAX));
                    c.rect_height = 9'($urandom_range(0, 3));
                end
                1: begin
                    c.rect_width  = 9'($urandom_range(0, 3));
                    c.rect_height = 9'($urandom_range(0, COORD_MAX));
                end
                default: begin
                    c.rect_width  = 9'($urandom_range(0, 15));
                    c.rect_height = 9'($urandom_range(0, 15));
                end
            endcase
        end else if (p < 61) begin
            c.opcode = OP_FILL_BUF;
        end else if (p < 97) begin
            c.opcode = OP_READ_BYTE;
            case ($urandom_range(0, 19))
                0:       c.byte_address = 13'($urandom_range(0, ADDR_MAX));
                1, 2, 3: c.byte_address = 13'($urandom_range(0, STORE_BYTES - 1));
                default: begin
                    rx = clamp(last_x + int'($urandom_range(0, 24)) - 12, WIDTH - 1);
                    ry = clamp(last_y + int'($urandom_range(0, 8)) - 4, HEIGHT - 1);
                    c.byte_address = 13'(ry * ROW_BYTES + rx / 8);
                end
            endcase
        end else begin
            c.opcode = 3'($urandom_range(OP_FIRST_UNUSED, OP_LAST_UNUSED));
        end
        return c;
    endfunction

    // one beat: present at the falling edge, hold until accepted
    task automatic send_command(t_cmd c);
        @(negedge i_clk);
        start  <= 1'b1;
        cmd_in <= c;
        do @(posedge i_clk); while (busy);
        board.note_command(c);
    endtask

    // bursts of back-to-back beats separated by random gaps
    task automatic pace_sender();
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            case ($urandom_range(0, 9))
                0, 1, 2: gap = 0;
                3:       gap = $urandom_range(10, 60);
                default: gap = $urandom_range(1, 6);
            endcase
            if (gap > 0) begin
                @(negedge i_clk);
                start  <= 1'b0;
                cmd_in <= random_command();
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        burst_left--;
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        t_cmd directed_q[$];
        int   waited;

        board      = new();
        burst_left = 0;
        last_x     = 0;
        last_y     = 0;
        i_rst_n    = 1'b0;
        start      = 1'b0;
        cmd_in     = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // store edges after reset, address range edges, then painting corners
        directed_q.push_back(make_cmd(OP_READ_BYTE, 0, 0, 0, 0, 0, 0, 0, 0));
        directed_q.push_back(make_cmd(OP_READ_BYTE, 0, 0, 0, 0, 0, 0, 0, STORE_BYTES - 1));
        directed_q.push_back(make_cmd(OP_READ_BYTE, 0, 0, 0, 0, 0, 0, 0, STORE_BYTES));
        directed_q.push_back(make_cmd(OP_READ_BYTE, 0, 0, 0, 0, 0, 0, 0, ADDR_MAX));
        directed_q.push_back(make_cmd(OP_FILL_BUF, 0, 0, 0, 0, 0, 0, 8'h00, 0));
        directed_q.push_back(make_cmd(OP_SET_PIXEL, 0, 0, 0, 0, 0, 0, 255, 0));
        directed_q.push_back(make_cmd(OP_SET_PIXEL, WIDTH - 1, HEIGHT - 1, 0, 0, 0, 0, 1, 0));
        // off-display pixels are dropped
        directed_q.push_back(make_cmd(OP_SET_PIXEL, WIDTH, 0, 0, 0, 0, 0, 1, 0));
        directed_q.push_back(make_cmd(OP_SET_PIXEL, COORD_MAX, COORD_MAX, 0, 0, 0, 0, 1, 0));
        directed_q.push_back(make_cmd(OP_READ_BYTE, 0, 0, 0, 0, 0, 0, 0, ROW_BYTES));
        directed_q.push_back(make_cmd(OP_DRAW_LINE, 0, 5, WIDTH - 1, 5, 0, 0, 7, 0));
        // line leaving the display, steep reversed line, single-point line
        directed_q.push_back(make_cmd(OP_DRAW_LINE, 190, 100, 250, 190, 0, 0, 1, 0));
        directed_q.push_back(make_cmd(OP_DRAW_LINE, 10, 150, 3, 120, 0, 0, 1, 0));
        directed_q.push_back(make_cmd(OP_DRAW_LINE, 50, 50, 50, 50, 0, 0, 1, 0));
        // rectangles clipped at the right and bottom, and empty ones
        directed_q.push_back(make_cmd(OP_FILL_RECT, 195, 195, 0, 0, COORD_MAX, 1, 1, 0));
        directed_q.push_back(make_cmd(OP_FILL_RECT, 7, 9, 0, 0, 1, COORD_MAX, 1, 0));
        directed_q.push_back(make_cmd(OP_FILL_RECT, 20, 20, 0, 0, 0, 10, 1, 0));
        directed_q.push_back(make_cmd(OP_FILL_RECT, 20, 20, 0, 0, 10, 0, 1, 0));
        directed_q.push_back(make_cmd(OP_FIRST_UNUSED, 1, 1, 2, 2, 3, 3, 1, 0));
        directed_q.push_back(make_cmd(OP_LAST_UNUSED, 1, 1, 2, 2, 3, 3, 1, 0));
        directed_q.push_back(make_cmd(OP_FILL_BUF, 0, 0, 0, 0, 0, 0, 8'hA5, 0));
        directed_q.push_back(make_cmd(OP_SET_PIXEL, 0, 0, 0, 0, 0, 0, 0, 0));
        directed_q.push_back(make_cmd(OP_READ_BYTE, 0, 0, 0, 0, 0, 0, 0, 0));
        directed_q.push_back(make_cmd(OP_DRAW_LINE, COORD_MAX, COORD_MAX, 0, 0, 0, 0, 0, 0));
        directed_q.push_back(make_cmd(OP_READ_BYTE, 0, 0, 0, 0, 0, 0, 0, STORE_BYTES - 1));
        foreach (directed_q[k]) begin
            pace_sender();
            send_command(directed_q[k]);
        end

        repeat (RANDOM_ITEMS) begin
            pace_sender();
            send_command(random_command());
        end
        @(negedge i_clk);
        start <= 1'b0;

        waited = 0;
        while (board.pending() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (board.pending() != 0)
            $display("%0t: %0d result beats never arrived", $time, board.pending());

        $display("covered %0d commands: %0d pixel, %0d line, %0d rect, %0d buffer fill,",
                 board.checked + board.pending(), board.op_count[OP_SET_PIXEL],
                 board.op_count[OP_DRAW_LINE], board.op_count[OP_FILL_RECT],
                 board.op_count[OP_FILL_BUF]);
        $display("  %0d byte reads, %0d unused opcodes; %0d result beats checked",
                 board.op_count[OP_READ_BYTE],
                 board.checked + board.pending() - board.op_count[OP_SET_PIXEL]
                 - board.op_count[OP_DRAW_LINE] - board.op_count[OP_FILL_RECT]
                 - board.op_count[OP_FILL_BUF] - board.op_count[OP_READ_BYTE],
                 board.checked);
        if (board.mismatches == 0 && board.pending() == 0) begin
            $display("mono_framebuffer_line_drawer_tb passed");
        end else begin
            $display("mono_framebuffer_line_drawer_tb failed");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("mono_framebuffer_line_drawer_tb failed");
        $finish;
    end

endmodule

// File: sim.f
rtl/core/mfld_pkg.sv
rtl/core/mfld_frame_ram.sv
rtl/core/mono_framebuffer_line_drawer.sv
dv/mono_framebuffer_line_drawer_tb.sv
